/* hw/rtl/svpd_pkg.sv */
// Shared types, register indexes, reset values and coil tables for the
// stepper valve position drive. No dependencies.
package svpd_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] target;
        logic [7:0]  overrun_extra;
        logic        origin_sensor;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  coils;
        logic        running;
        logic [15:0] position;
        logic        start_accepted;
    } t_out_beat;

    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_INTERVAL   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXCITATION_TYPE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_OPEN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_ENABLED   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERRUN_LIMIT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALL_THRESHOLD  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_OFFSET     = 3'd6;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    localparam logic [1:0] EXC_ONE_PHASE     = 2'd0;
    localparam logic [1:0] EXC_ONE_TWO_PHASE = 2'd1;
    localparam logic [1:0] EXC_TWO_PHASE     = 2'd2;
    localparam logic [1:0] EXC_NO_DRIVE      = 2'd3;

    localparam logic [15:0] RST_STEP_INTERVAL   = 16'd15;
    localparam logic [1:0]  RST_EXCITATION_TYPE = EXC_ONE_TWO_PHASE;
    localparam logic        RST_NORMAL_OPEN     = 1'b0;
    localparam logic        RST_DRIVE_ENABLED   = 1'b1;
    localparam logic [15:0] RST_OVERRUN_LIMIT   = 16'd200;
    localparam logic [15:0] RST_HALL_THRESHOLD  = 16'd50;
    localparam logic [15:0] RST_ZERO_OFFSET     = 16'd480;

    localparam logic [3:0] ONE_PHASE_TAB [8] = '{4'd8, 4'd8, 4'd4, 4'd4,
                                                4'd2, 4'd2, 4'd1, 4'd1};
    localparam logic [3:0] HALF_STEP_TAB [8] = '{4'd12, 4'd4, 4'd6, 4'd2,
                                                4'd3, 4'd1, 4'd9, 4'd8};
    localparam logic [3:0] TWO_PHASE_TAB [8] = '{4'd12, 4'd6, 4'd3, 4'd9,
                                                4'd12, 4'd6, 4'd3, 4'd9};

    // coil pattern for a phase; no-drive leaves the coils off
    function automatic logic [3:0] coil_pattern(input logic [1:0] exc,
                                                input logic [2:0] phase);
        logic [3:0] pat;
        pat = 4'd0;
        unique case (exc)
            EXC_ONE_PHASE:     pat = ONE_PHASE_TAB[phase];
            EXC_ONE_TWO_PHASE: pat = HALF_STEP_TAB[phase];
            EXC_TWO_PHASE:     pat = TWO_PHASE_TAB[phase];
            default:           pat = 4'd0;
        endcase
        return pat;
    endfunction

endpackage

/* hw/rtl/stepper_valve_position_drive.sv */
// Top level of the stepper valve position drive: beat register, step logic,
// state and result register. Depends on svpd_pkg.
//
// Takes one beat per clock unless the result is stalled and returns one result
// per beat: the beat is registered, then the state update and the result are
// computed from that register and the drive state and held in the result
// register. Throughput is one beat per cycle while not stalled; a stalled result
// holds the input register and back-pressure reaches the input after one beat of slack.
// The configuration port is always ready and should be written only while
// no beat is in flight.
module stepper_valve_position_drive (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  svpd_pkg::t_in_beat                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output svpd_pkg::t_out_beat               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svpd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    // configuration
    logic [15:0] r_step_interval;
    logic [1:0]  r_excitation_type;
    logic        r_normal_open;
    logic        r_drive_enabled;
    logic [15:0] r_overrun_limit;
    logic [15:0] r_hall_threshold;
    logic [15:0] r_zero_offset;

    // pipeline
    logic                r_in_valid;
    svpd_pkg::t_in_beat  r_in;
    logic                r_out_valid;
    svpd_pkg::t_out_beat r_out;
    logic                advance;

    // drive state
    logic [15:0] r_cur_position,      n_cur_position;
    logic [15:0] r_goal_position,     n_goal_position;
    logic [15:0] r_hall_overrun_count, n_hall_overrun_count;
    logic [7:0]  r_hysteresis_pending, n_hysteresis_pending;
    logic [15:0] r_learned_max_overrun, n_learned_max_overrun;
    logic [15:0] r_origin_position,   n_origin_position;
    logic        r_origin_seen,       n_origin_seen;
    logic [2:0]  r_coil_phase,        n_coil_phase;
    logic        r_move_active,       n_move_active;
    logic [15:0] r_interval_count,    n_interval_count;
    logic [3:0]  r_coil_state,        n_coil_state;
    logic        r_origin_latch,      n_origin_latch;
    logic        n_accepted;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval   <= svpd_pkg::RST_STEP_INTERVAL;
            r_excitation_type <= svpd_pkg::RST_EXCITATION_TYPE;
            r_normal_open     <= svpd_pkg::RST_NORMAL_OPEN;
            r_drive_enabled   <= svpd_pkg::RST_DRIVE_ENABLED;
            r_overrun_limit   <= svpd_pkg::RST_OVERRUN_LIMIT;
            r_hall_threshold  <= svpd_pkg::RST_HALL_THRESHOLD;
            r_zero_offset     <= svpd_pkg::RST_ZERO_OFFSET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                svpd_pkg::CFG_STEP_INTERVAL:   r_step_interval   <= i_cfg_data;
                svpd_pkg::CFG_EXCITATION_TYPE: r_excitation_type <= i_cfg_data[1:0];
                svpd_pkg::CFG_NORMAL_OPEN:     r_normal_open     <= i_cfg_data[0];
                svpd_pkg::CFG_DRIVE_ENABLED:   r_drive_enabled   <= i_cfg_data[0];
                svpd_pkg::CFG_OVERRUN_LIMIT:   r_overrun_limit   <= i_cfg_data;
                svpd_pkg::CFG_HALL_THRESHOLD:  r_hall_threshold  <= i_cfg_data;
                svpd_pkg::CFG_ZERO_OFFSET:     r_zero_offset     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [15:0] ic_dec;
        logic [15:0] lm_raw;
        n_cur_position        = r_cur_position;
        n_goal_position       = r_goal_position;
        n_hall_overrun_count  = r_hall_overrun_count;
        n_hysteresis_pending  = r_hysteresis_pending;
        n_learned_max_overrun = r_learned_max_overrun;
        n_origin_position     = r_origin_position;
        n_origin_seen         = r_origin_seen;
        n_coil_phase          = r_coil_phase;
        n_move_active         = r_move_active;
        n_interval_count      = r_interval_count;
        n_coil_state          = r_coil_state;
        n_origin_latch        = r_origin_latch;
        n_accepted            = 1'b0;
        ic_dec = (r_interval_count != 16'd0) ? r_interval_count - 16'd1 : 16'd0;
        lm_raw = r_origin_position - r_hall_threshold;

        if (r_in.mode == svpd_pkg::MODE_START) begin
            if (!r_move_active && r_cur_position != r_in.target) begin
                n_accepted = 1'b1;
                if (r_in.target == 16'd0) begin
                    n_hall_overrun_count = 16'd0;
                    n_cur_position       = r_cur_position + r_zero_offset;
                    n_goal_position      = 16'd0;
                end else if (r_cur_position >= r_in.target) begin
                    n_hall_overrun_count = 16'd0;
                    n_hysteresis_pending = 8'd0;
                    n_goal_position      = r_in.target;
                end else begin
                    n_hysteresis_pending = r_in.overrun_extra;
                    n_goal_position      = r_in.target + {8'd0, r_in.overrun_extra};
                end
                n_move_active    = 1'b1;
                n_interval_count = r_step_interval;
            end
        end else begin
            n_origin_latch   = r_in.origin_sensor;
            n_interval_count = ic_dec;
            if (r_drive_enabled && ic_dec == 16'd0) begin
                n_interval_count = r_step_interval;
                n_coil_state     = 4'd0;
                if (r_move_active) begin
                    if (r_goal_position > r_cur_position) begin
                        // open step
                        n_cur_position = r_cur_position + 16'd1;
                        n_coil_phase   = r_coil_phase + (r_normal_open ? 3'd7 : 3'd1);
                        if (r_in.origin_sensor) begin
                            n_origin_position = r_cur_position + 16'd1;
                            n_origin_seen     = 1'b1;
                        end else if (r_origin_seen) begin
                            n_learned_max_overrun = (lm_raw > r_overrun_limit) ?
                                                    r_overrun_limit : lm_raw;
                        end
                        n_coil_state = svpd_pkg::coil_pattern(r_excitation_type,
                                                              n_coil_phase);
                    end else if (r_goal_position < r_cur_position) begin
                        if (r_in.origin_sensor &&
                            r_hall_overrun_count >= r_learned_max_overrun) begin
                            n_goal_position      = 16'd0;
                            n_cur_position       = 16'd0;
                            n_hall_overrun_count = 16'd0;
                            n_move_active        = 1'b0;
                        end else begin
                            // close step; cur is above goal so never zero here
                            if (r_in.origin_sensor) begin
                                n_hall_overrun_count = r_hall_overrun_count + 16'd1;
                            end
                            n_cur_position = r_cur_position - 16'd1;
                            n_coil_phase   = r_coil_phase + (r_normal_open ? 3'd1 : 3'd7);
                            if (n_cur_position == 16'd0) begin
                                n_goal_position      = 16'd0;
                                n_hall_overrun_count = 16'd0;
                                n_move_active        = 1'b0;
                            end else begin
                                n_coil_state = svpd_pkg::coil_pattern(r_excitation_type,
                                                                      n_coil_phase);
                            end
                        end
                    end else if (r_goal_position != 16'd0 &&
                                 r_hysteresis_pending != 8'd0) begin
                        // back off the hysteresis overshoot
                        n_goal_position      = r_goal_position -
                                               {8'd0, r_hysteresis_pending};
                        n_hysteresis_pending = 8'd0;
                    end else begin
                        n_hall_overrun_count = 16'd0;
                        n_move_active        = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_cur_position        <= 16'd0;
            r_goal_position       <= 16'd0;
            r_hall_overrun_count  <= 16'd0;
            r_hysteresis_pending  <= 8'd0;
            r_learned_max_overrun <= svpd_pkg::RST_OVERRUN_LIMIT;
            r_origin_position     <= 16'd0;
            r_origin_seen         <= 1'b0;
            r_coil_phase          <= 3'd0;
            r_move_active         <= 1'b0;
            r_interval_count      <= 16'd0;
            r_coil_state          <= 4'd0;
            r_origin_latch        <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
                r_in       <= i_in_data;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid               <= 1'b1;
                r_out.coils               <= n_coil_state;
                r_out.running             <= n_move_active;
                r_out.position            <= n_cur_position;
                r_out.start_accepted      <= n_accepted;
                r_cur_position            <= n_cur_position;
                r_goal_position           <= n_goal_position;
                r_hall_overrun_count      <= n_hall_overrun_count;
                r_hysteresis_pending      <= n_hysteresis_pending;
                r_learned_max_overrun     <= n_learned_max_overrun;
                r_origin_position         <= n_origin_position;
                r_origin_seen             <= n_origin_seen;
                r_coil_phase              <= n_coil_phase;
                r_move_active             <= n_move_active;
                r_interval_count          <= n_interval_count;
                r_coil_state              <= n_coil_state;
                r_origin_latch            <= n_origin_latch;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // coils are always off while no move is in progress
    a_idle_coils_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_move_active |-> r_coil_state == 4'd0)
        else $error("coils driven while idle");

    // an accepted start always leaves a move running
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start_accepted |-> r_out.running)
        else $error("accepted start without a running move");

    // a held beat is not dropped while the result side is stalled
    a_beat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("held beat lost");

endmodule
